// ===== src/ucfd_pkg.sv =====
// Shared constants, types and the frame decode result for the CAN frame deframer.
package ucfd_pkg;

    localparam int FRAME_LEN = 18;
    localparam int SUM_LEN   = FRAME_LEN - 1;
    localparam int FILL_W    = 5;
    localparam int ID_W      = 11;
    localparam int DATA_N    = 8;
    localparam int DATA_POS  = 9;
    localparam int ADDR_W    = 3;
    localparam int APB_W     = 32;

    localparam logic [7:0] START_BYTE     = 8'hF0;
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h00;
    localparam logic [7:0] TYPE_STATUS    = 8'h55;
    localparam logic [7:0] CHANNEL_A      = 8'hAA;

    localparam logic [ID_W-1:0] ID_LOW_RST  = 11'd1024;
    localparam logic [ID_W-1:0] ID_HIGH_RST = 11'd1031;

    // Register index as taken from paddr[2]
    localparam logic REG_ID_LOW  = 1'b0;
    localparam logic REG_ID_HIGH = 1'b1;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SUM_LEN);

    typedef logic [7:0] byte_t;
    typedef logic [SUM_LEN-1:0][7:0] window_t;
    typedef logic [DATA_N-1:0][7:0] payload_t;

    typedef struct packed {
        logic            frame_ok;
        logic            hit;
        logic [ID_W-1:0] can_id;
        payload_t        data;
    } dec_t;

endpackage

// ===== src/ucfd_rx_if.sv =====
// Received byte channel: valid/ready handshake carrying one raw byte.
interface ucfd_rx_if import ucfd_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/ucfd_can_if.sv =====
// CAN packet channel: valid/ready handshake carrying identifier and eight data bytes.
interface ucfd_can_if import ucfd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] can_id;
    byte_t           data0;
    byte_t           data1;
    byte_t           data2;
    byte_t           data3;
    byte_t           data4;
    byte_t           data5;
    byte_t           data6;
    byte_t           data7;

    modport source (output valid, output can_id, output data0, output data1, output data2,
                    output data3, output data4, output data5, output data6, output data7,
                    input ready);
    modport sink (input valid, input can_id, input data0, input data1, input data2,
                  input data3, input data4, input data5, input data6, input data7,
                  output ready);
endinterface

// ===== src/ucfd_frame_decode.sv =====
// Frame check and decode: start byte, folded checksum, type, channel and identifier range.
module ucfd_frame_decode import ucfd_pkg::*;
(
    input  window_t         head,
    input  byte_t           tail,
    input  logic [ID_W-1:0] id_low,
    input  logic [ID_W-1:0] id_high,
    output dec_t            dec
);

    logic [8:0]  lvl1 [9];
    logic [9:0]  lvl2 [5];
    logic [10:0] lvl3 [3];
    logic [12:0] sum;
    logic [8:0]  fold1;
    logic [8:0]  fold2;
    byte_t       cks;
    logic        is_status;
    logic        is_heartbeat;
    logic [ID_W-1:0] id;

    // Adder tree over the first seventeen bytes
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lvl1[i] = {1'b0, head[2*i]} + {1'b0, head[2*i+1]};
        end
        lvl1[8] = {1'b0, head[16]};
        for (int i = 0; i < 4; i++)
        begin
            lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
        end
        lvl2[4] = {1'b0, lvl1[8]};
        lvl3[0] = {1'b0, lvl2[0]} + {1'b0, lvl2[1]};
        lvl3[1] = {1'b0, lvl2[2]} + {1'b0, lvl2[3]};
        lvl3[2] = {1'b0, lvl2[4]};
        sum     = {2'b00, lvl3[0]} + {2'b00, lvl3[1]} + {2'b00, lvl3[2]};
    end

    // Fold the carries back in twice, then negate
    assign fold1 = {1'b0, sum[7:0]} + {4'b0000, sum[12:8]};
    assign fold2 = {1'b0, fold1[7:0]} + {8'h00, fold1[8]};
    assign cks   = 8'h00 - fold2[7:0];

    assign is_heartbeat = (head[1] == TYPE_HEARTBEAT);
    assign is_status    = (head[1] == TYPE_STATUS) && (head[2] == CHANNEL_A);
    assign id           = {head[4], head[5][7:5]};

    always_comb
    begin
        dec.frame_ok = (head[0] == START_BYTE) && (cks == tail);
        dec.hit      = dec.frame_ok && !is_heartbeat && is_status
                       && (id >= id_low) && (id <= id_high);
        dec.can_id   = id;
        for (int i = 0; i < DATA_N; i++)
        begin
            dec.data[i] = head[DATA_POS + i];
        end
    end

endmodule

// ===== src/usb_can_frame_deframer_core.sv =====
// Top level of the received-byte deframer that extracts CAN status packets.
//
// Takes one received byte per transfer on rx and emits one CAN packet per
// accepted status frame on can. The block takes one byte per clock while
// the result register is free or being drained: a byte is registered on
// entry, and the frame check (a 17-byte adder tree, two carry folds and a
// compare) plus the type and identifier-range decode run between that
// input register and the result register, so a packet is offered on can
// from the result register once the byte that completes its frame has
// passed the input register. The result register is a true output stage:
// while a packet waits on can, the next byte is still taken into the
// input register, and both stages advance together as soon as the packet
// is transferred. The window is a 17-byte shift line plus a fill count;
// a frame is tested only when 17 bytes are held and the 18th arrives.
// A failed test drops the oldest byte, a passing one empties the window.
// id_low (offset 0x0) and id_high (offset 0x4) are 11-bit APB registers,
// reset to 1024 and 1031; write them only while the block is idle. An
// empty range (id_low above id_high) rejects every status frame.
module usb_can_frame_deframer_core import ucfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    ucfd_rx_if.sink           rx,
    ucfd_can_if.source        can,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic [ID_W-1:0]   id_low_reg;
    logic [ID_W-1:0]   id_high_reg;

    logic              s1_valid_reg;
    byte_t             s1_byte_reg;

    window_t           hist_reg;
    logic [FILL_W-1:0] fill_count_reg;
    logic [FILL_W-1:0] fill_count_next;

    logic              out_valid_reg;
    logic [ID_W-1:0]   can_id_reg;
    payload_t          data_reg;

    logic              advance;
    logic              s1_go;
    logic              window_full;
    logic              cfg_write;
    dec_t              dec;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_low_reg  <= ID_LOW_RST;
            id_high_reg <= ID_HIGH_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ID_LOW:  id_low_reg  <= pwdata[ID_W-1:0];
                REG_ID_HIGH: id_high_reg <= pwdata[ID_W-1:0];
                default:     id_low_reg  <= id_low_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ID_LOW:  prdata = {{(APB_W-ID_W){1'b0}}, id_low_reg};
            REG_ID_HIGH: prdata = {{(APB_W-ID_W){1'b0}}, id_high_reg};
            default:     prdata = '0;
        endcase
    end

    // Both stages move whenever the result register is free or being drained
    assign advance  = !out_valid_reg || can.ready;
    assign s1_go    = s1_valid_reg && advance;
    assign rx.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
    end

    // Frame check on the held 17 bytes with the new byte as the checksum
    ucfd_frame_decode u_decode
    (
        .head    (hist_reg),
        .tail    (s1_byte_reg),
        .id_low  (id_low_reg),
        .id_high (id_high_reg),
        .dec     (dec)
    );

    assign window_full = (fill_count_reg == FILL_FULL);

    // Full window: empty it on a good frame, otherwise drop the oldest byte
    always_comb
    begin
        if (!window_full)
        begin
            fill_count_next = fill_count_reg + 1'b1;
        end
        else if (dec.frame_ok)
        begin
            fill_count_next = '0;
        end
        else
        begin
            fill_count_next = FILL_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else if (s1_go)
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // Shift line: oldest byte at index 0, newest at the top
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            for (int i = 0; i < SUM_LEN - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[SUM_LEN-1] <= s1_byte_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_go && window_full && dec.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && window_full && dec.hit)
        begin
            can_id_reg <= dec.can_id;
            data_reg   <= dec.data;
        end
    end

    assign can.valid  = out_valid_reg;
    assign can.can_id = can_id_reg;
    assign can.data0  = data_reg[0];
    assign can.data1  = data_reg[1];
    assign can.data2  = data_reg[2];
    assign can.data3  = data_reg[3];
    assign can.data4  = data_reg[4];
    assign can.data5  = data_reg[5];
    assign can.data6  = data_reg[6];
    assign can.data7  = data_reg[7];

`ifndef NO_ASSERTIONS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_FULL)
        else $error("fill count beyond a full window");

    a_good_frame_empties: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && window_full && dec.frame_ok |=> fill_count_reg == '0)
        else $error("window not emptied after a good frame");

    a_bad_frame_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && window_full && !dec.frame_ok |=> fill_count_reg == FILL_FULL)
        else $error("window not held full after a failed check");

    a_result_from_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_go) && $past(window_full))
        else $error("packet raised without a completed frame");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (can_id_reg >= id_low_reg) && (can_id_reg <= id_high_reg))
        else $error("packet identifier outside the configured range");
`endif

endmodule

// ===== sim/usb_can_frame_deframer_core_tb.sv =====
// Testbench for the CAN frame deframer: byte stream stimulus, frame decode prediction, packet checks.
`timescale 1ns / 100ps

module usb_can_frame_deframer_core_tb;
    import ucfd_pkg::*;

    // Full 18-byte frame, byte k of the frame at index k
    typedef logic [FRAME_LEN-1:0][7:0] frame_t;

    // One CAN packet as it leaves the block
    typedef struct packed {
        logic [ID_W-1:0] can_id;
        payload_t        data;
    } can_pkt_t;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 6;

    logic clk;
    logic rst_n;

    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0] pwdata;
    logic [APB_W-1:0] prdata;
    logic             pready;

    ucfd_rx_if  rx_ch ();
    ucfd_can_if can_ch ();

    usb_can_frame_deframer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .can     (can_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bytes still to be offered on rx, filled phase by phase
    byte_t    link_bytes[$];
    // CAN packets the decode says must still come out, oldest first
    can_pkt_t pending_can_pkts[$];

    // Shadow of the deframer: window, fill count and identifier range
    frame_t          shadow_window;
    int              shadow_fill;
    logic [ID_W-1:0] range_low;
    logic [ID_W-1:0] range_high;

    // Idling and pressure controls
    logic idle_en;
    logic hold_go;
    logic can_hold;
    int   rx_gap;
    int   can_gap;

    // Run statistics
    int mismatches;
    int bytes_in;
    int pkts_predicted;
    int pkts_seen;
    int ranges_used;

    // ------------------------------------------------------------------
    // Clock, and a watchdog that ends a hung run
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("[usb_can_frame_deframer_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame arithmetic
    // ------------------------------------------------------------------

    // End-around-carry checksum over frame bytes 0..16: fold the 16-bit
    // sum into 8 bits twice, then negate.
    function automatic byte_t frame_sum(input frame_t f);
        logic [15:0] s;
        s = '0;
        for (int k = 0; k < SUM_LEN; k++)
            s = s + {8'h00, f[k]};
        s = {8'h00, s[7:0]} + {8'h00, s[15:8]};
        s = {8'h00, s[7:0]} + {8'h00, s[15:8]};
        return 8'h00 - s[7:0];
    endfunction

    // Build a sealed frame: start byte, type, channel and identifier as
    // given, payload either fixed or random, every other byte random.
    function automatic frame_t make_frame(input byte_t kind, input byte_t chan,
                                          input logic [ID_W-1:0] id,
                                          input logic fixed_pay, input byte_t pay);
        frame_t f;
        for (int k = 0; k < FRAME_LEN; k++)
            f[k] = byte_t'($urandom);
        f[0]      = START_BYTE;
        f[1]      = kind;
        f[2]      = chan;
        f[4]      = id[10:3];
        f[5][7:5] = id[2:0];
        if (fixed_pay)
            for (int k = 0; k < DATA_N; k++)
                f[DATA_POS + k] = pay;
        f[FRAME_LEN-1] = frame_sum(f);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Decode prediction: advance the shadow window by one received byte
    // and queue the CAN packet it releases, if any.
    // ------------------------------------------------------------------
    function automatic void deframe_byte(input byte_t b);
        logic [ID_W-1:0] id;
        can_pkt_t        pkt;
        if (shadow_fill >= FRAME_LEN)
            shadow_fill = 0;
        shadow_window[shadow_fill] = b;
        shadow_fill++;
        if (shadow_fill < FRAME_LEN)
            return;
        // No frame here: drop the oldest byte and keep sliding
        if (shadow_window[0] != START_BYTE ||
            frame_sum(shadow_window) != shadow_window[FRAME_LEN-1])
        begin
            shadow_window = shadow_window >> 8;
            shadow_fill   = FRAME_LEN - 1;
            return;
        end
        // Frame consumed whole; heartbeats and other types end here
        shadow_fill = 0;
        if (shadow_window[1] != TYPE_STATUS || shadow_window[2] != CHANNEL_A)
            return;
        id = {shadow_window[4], shadow_window[5][7:5]};
        if (id < range_low || id > range_high)
            return;
        pkt.can_id = id;
        for (int k = 0; k < DATA_N; k++)
            pkt.data[k] = shadow_window[DATA_POS + k];
        pending_can_pkts.push_back(pkt);
        pkts_predicted++;
    endfunction

    // ------------------------------------------------------------------
    // rx driver: offer queued bytes, with random idle bursts
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : rx_driver
        logic nv;
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
        end
        else if (!rx_ch.valid || rx_ch.ready)
        begin
            // Previous byte gone (or none on offer): pick the next one
            if (rx_gap == 0 && idle_en && $urandom_range(0, 7) == 0)
                rx_gap = $urandom_range(1, 9);
            nv = (rx_gap == 0) && (link_bytes.size() != 0);
            if (rx_gap > 0)
                rx_gap--;
            if (nv)
                rx_ch.rx_byte <= link_bytes.pop_front();
            rx_ch.valid <= nv;
        end
    end

    // ------------------------------------------------------------------
    // can receiver: random stall bursts, plus the long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : can_receiver
        if (!rst_n)
        begin
            can_ch.ready <= 1'b0;
        end
        else
        begin
            if (can_gap == 0 && idle_en && $urandom_range(0, 5) == 0)
                can_gap = $urandom_range(1, 9);
            can_ch.ready <= (can_gap == 0) && !can_hold;
            if (can_gap > 0)
                can_gap--;
        end
    end

    // Hold the receiver off for a long stretch once asked, so that the
    // output stage fills and the block has to stall rx.
    initial
    begin : receiver_hold_off
        can_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        can_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        can_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every rx transfer, check every can transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : transfer_monitor
        can_pkt_t got;
        can_pkt_t want;
        logic     bad;
        if (rst_n)
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                deframe_byte(rx_ch.rx_byte);
                bytes_in++;
            end
            if (can_ch.valid && can_ch.ready)
            begin
                got.can_id = can_ch.can_id;
                got.data   = {can_ch.data7, can_ch.data6, can_ch.data5, can_ch.data4,
                              can_ch.data3, can_ch.data2, can_ch.data1, can_ch.data0};
                pkts_seen++;
                if (pending_can_pkts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: packet with none pending: id=%0d data7..0=%h",
                                 $realtime, got.can_id, got.data);
                end
                else
                begin
                    want = pending_can_pkts.pop_front();
                    bad  = (got.can_id !== want.can_id);
                    for (int k = 0; k < DATA_N; k++)
                        if (got.data[k] !== want.data[k])
                            bad = 1'b1;
                    if (bad)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: packet mismatch: id exp %0d got %0d, ",
                                      "data7..0 exp %h got %h"},
                                     $realtime, want.can_id, got.can_id, want.data, got.data);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one identifier register over APB: setup, then access
    task automatic apb_write(input logic idx, input logic [ID_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ID_LOW)
            range_low = val;
        else
            range_high = val;
    endtask

    task automatic apply_range(input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi);
        apb_write(REG_ID_LOW, lo);
        apb_write(REG_ID_HIGH, hi);
        ranges_used++;
        @(negedge clk);
    endtask

    task automatic push_bytes(input frame_t f, input int len);
        for (int k = 0; k < len; k++)
            link_bytes.push_back(f[k]);
    endtask

    // Identifier for a status frame: mostly inside the current range,
    // with the bounds and their outer neighbours favoured.
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (range_low <= range_high && r < 7)
        begin
            if (r == 0)
                return range_low;
            if (r == 1)
                return range_high;
            return ID_W'($urandom_range(range_low, range_high));
        end
        if (r == 7)
            return range_low - 1'b1;
        if (r == 8)
            return range_high + 1'b1;
        return ID_W'($urandom_range(0, 2047));
    endfunction

    // Queue about n bytes of traffic: mostly sealed frames of every kind,
    // the rest broken checksums, cut-off frames and line noise.
    task automatic queue_traffic(input int n);
        int     r;
        int     len;
        frame_t f;
        while (link_bytes.size() < n)
        begin
            r   = $urandom_range(0, 99);
            len = FRAME_LEN;
            f   = make_frame(TYPE_STATUS, CHANNEL_A, pick_id(), 1'b0, 8'h00);
            if (r >= 60 && r < 68)
                f = make_frame(TYPE_HEARTBEAT, byte_t'($urandom), pick_id(), 1'b0, 8'h00);
            else if (r >= 68 && r < 72)
                f = make_frame(TYPE_STATUS, byte_t'($urandom), pick_id(), 1'b0, 8'h00);
            else if (r >= 72 && r < 76)
                f = make_frame(byte_t'($urandom), CHANNEL_A, pick_id(), 1'b0, 8'h00);
            else if (r >= 76 && r < 86)
                f[FRAME_LEN-1] = f[FRAME_LEN-1] ^ byte_t'($urandom_range(1, 255));
            else if (r >= 86 && r < 93)
                len = $urandom_range(1, FRAME_LEN - 1);
            else if (r >= 93)
                len = 0;
            if (len == 0)
            begin
                // Noise, with stray start bytes to provoke false alignment
                repeat ($urandom_range(1, 12))
                    link_bytes.push_back(($urandom_range(0, 3) == 0) ? START_BYTE
                                                                    : byte_t'($urandom));
            end
            else
            begin
                push_bytes(f, len);
            end
        end
    endtask

    // Let everything queued go through, every predicted packet come out,
    // then give the pipeline time to finish a byte that gives nothing.
    task automatic drain();
        while (link_bytes.size() != 0 || rx_ch.valid || pending_can_pkts.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        frame_t          f;
        int              phase;
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;

        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        can_ch.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_en        = 1'b1;
        hold_go        = 1'b0;
        rx_gap         = 0;
        can_gap        = 0;
        mismatches     = 0;
        bytes_in       = 0;
        pkts_predicted = 0;
        pkts_seen      = 0;
        ranges_used    = 1;
        shadow_window  = '0;
        shadow_fill    = 0;
        range_low      = ID_LOW_RST;
        range_high     = ID_HIGH_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames against the reset range 1024..1031: both bounds
        // with all-zero and all-one payloads, one either side, heartbeat,
        // unknown type, wrong channel, a broken checksum among noise, and
        // a clean frame to show the window realigns.
        push_bytes(make_frame(TYPE_STATUS, CHANNEL_A, ID_LOW_RST, 1'b1, 8'h00), FRAME_LEN);
        push_bytes(make_frame(TYPE_STATUS, CHANNEL_A, ID_HIGH_RST, 1'b1, 8'hFF), FRAME_LEN);
        push_bytes(make_frame(TYPE_STATUS, CHANNEL_A, ID_LOW_RST - 1'b1, 1'b0, 8'h00),
                   FRAME_LEN);
        push_bytes(make_frame(TYPE_STATUS, CHANNEL_A, ID_HIGH_RST + 1'b1, 1'b0, 8'h00),
                   FRAME_LEN);
        push_bytes(make_frame(TYPE_HEARTBEAT, CHANNEL_A, ID_LOW_RST, 1'b0, 8'h00), FRAME_LEN);
        push_bytes(make_frame(8'h12, CHANNEL_A, ID_LOW_RST + 11'd3, 1'b0, 8'h00), FRAME_LEN);
        push_bytes(make_frame(TYPE_STATUS, 8'h55, ID_LOW_RST + 11'd3, 1'b0, 8'h00), FRAME_LEN);
        f = make_frame(TYPE_STATUS, CHANNEL_A, ID_LOW_RST + 11'd4, 1'b0, 8'h00);
        f[FRAME_LEN-1] = f[FRAME_LEN-1] ^ 8'h01;
        push_bytes(f, FRAME_LEN);
        link_bytes.push_back(8'h00);
        link_bytes.push_back(8'hFF);
        link_bytes.push_back(START_BYTE);
        push_bytes(make_frame(TYPE_STATUS, CHANNEL_A, ID_LOW_RST + 11'd5, 1'b0, 8'h00),
                   FRAME_LEN);
        drain();

        // Full range, with the long receiver hold-off at its start
        apply_range(11'd0, 11'd2047);
        hold_go = 1'b1;
        queue_traffic(250);
        drain();

        // Single-identifier ranges at both ends, then an empty range
        apply_range(11'd0, 11'd0);
        queue_traffic(120);
        drain();
        apply_range(11'd2047, 11'd2047);
        queue_traffic(120);
        drain();
        apply_range(11'd1500, 11'd200);
        queue_traffic(120);
        drain();

        // Random ranges, every third phase without any idling
        phase = 0;
        while ((bytes_in < 1000 || pkts_predicted < 40) && phase < 10)
        begin
            lo = ID_W'($urandom_range(0, 2047));
            if ($urandom_range(0, 1) == 0)
                hi = ID_W'($urandom_range(lo, 2047));
            else
                hi = (lo > 2047 - 31) ? 11'd2047 : lo + ID_W'($urandom_range(0, 31));
            apply_range(lo, hi);
            idle_en = (phase % 3 != 2);
            queue_traffic(200);
            drain();
            phase++;
        end

        // Closing stretch: both sides at full rate
        lo = ID_W'($urandom_range(0, 1023));
        apply_range(lo, lo + ID_W'($urandom_range(0, 1023)));
        idle_en = 1'b0;
        queue_traffic(150);
        drain();

        repeat (10) @(negedge clk);
        if (pending_can_pkts.size() != 0)
        begin
            mismatches += pending_can_pkts.size();
            $display("%0d predicted packets never came out", pending_can_pkts.size());
        end

        $display("Ran %0d received bytes through %0d identifier ranges; %0d CAN packets checked.",
                 bytes_in, ranges_used, pkts_seen);
        $display("Included a %0d-cycle receiver stall and %0d mismatching transfers.",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("[usb_can_frame_deframer_core] OK");
        else
            $display("[usb_can_frame_deframer_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/ucfd_pkg.sv
src/ucfd_rx_if.sv
src/ucfd_can_if.sv
src/ucfd_frame_decode.sv
src/usb_can_frame_deframer_core.sv
sim/usb_can_frame_deframer_core_tb.sv
